// File: rtl/core/rrq_pkg.sv
// Shared types and constants of the round-robin ready queue.
package rrq_pkg;

  // Table depth and widths
  localparam int MAX_THREADS = 16;
  localparam int ID_W        = $clog2(MAX_THREADS);
  localparam int CNT_W       = $clog2(MAX_THREADS + 1);
  localparam int FIFO_DEPTH  = 2;

  // Opcodes of an input word; the last code is reserved and does nothing
  typedef enum logic [1:0] {
    OP_ADMIT  = 2'd0,
    OP_REMOVE = 2'd1,
    OP_POP    = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  // Error codes of a result word
  typedef enum logic [1:0] {
    ERR_OK     = 2'd0,
    ERR_DUP    = 2'd1,
    ERR_ABSENT = 2'd2,
    ERR_EMPTY  = 2'd3
  } err_t;

  // Back-end sequencer states
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  // Classified command passed from front to back
  typedef struct packed {
    op_t             op;
    logic [ID_W-1:0] id;
    logic            id_ok;
  } item_t;

  // One result word
  typedef struct packed {
    err_t             err;
    logic [CNT_W-1:0] length;
    logic             empty;
    logic [ID_W-1:0]  popped;
  } res_t;

  // Queue status seen by the top level
  typedef struct packed {
    logic [MAX_THREADS-1:0] queued;
    logic [CNT_W-1:0]       count;
  } status_t;

endpackage

// File: rtl/core/round_robin_ready_queue_core.sv
// Top level of the round-robin ready queue of thread ids.
//
// Input words arrive on s_tvalid/s_tready/s_tdata: a 2-bit opcode (admit,
// remove, pop, reserved) and a 4-bit thread id. Each word yields exactly one
// result word on m_tvalid/m_tready/m_tdata: the popped id, an empty flag,
// the queue length and an error code. The queue is a doubly linked list in
// two 16-entry link RAMs indexed by thread id, with a valid bit per id.
//
// A word passes a two-entry front queue. The back end then reads both link
// RAMs while idle and, in execute, updates links and the head, tail and
// count. It takes a new word only in idle, so it is through with one word
// before it takes another; the link RAMs have a registered read.
//
// Reset (rst, synchronous) empties the queue and clears all valid bits; the
// link RAMs are not cleared. When m_tready is low the result register
// holds, the back end waits in execute and the front queue keeps taking
// words until its two entries are full.
module round_robin_ready_queue_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [1:0] opcode, [5:2] thread_id, [7:6] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // [3:0] popped_id, [4] queue_empty,
                                 // [9:5] queue_length, [11:10] error_code, [15:12] zero
);

  logic              item_valid;
  logic              item_ready;
  rrq_pkg::item_t    item;
  rrq_pkg::res_t     res;
  rrq_pkg::status_t  status;

  rrq_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .opcode     (s_tdata[1:0]),
    .thread_id  (s_tdata[5:2]),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item)
  );

  rrq_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .res_valid  (m_tvalid),
    .res_ready  (m_tready),
    .res        (res),
    .status     (status)
  );

  // Pack the result word
  assign m_tdata = {4'b0000, res};

  // Count always matches the number of queued ids
  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    32'(status.count) == $countones(status.queued))
    else $error("queue count disagrees with valid bits");

  // Length never exceeds the table depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(status.count) <= rrq_pkg::MAX_THREADS)
    else $error("queue count beyond table depth");

  // A failed pop reports no id and an empty queue
  a_empty_pop: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && res.err == rrq_pkg::ERR_EMPTY) |-> (res.popped == '0 && res.empty))
    else $error("pop of empty queue reported wrongly");

  // Empty flag agrees with the reported length
  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (res.empty == (res.length == '0)))
    else $error("empty flag disagrees with length");

endmodule

// File: rtl/core/rrq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rrq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: rtl/core/rrq_front.sv
// Front end: accepts input words, decodes them and buffers them in a short queue.
module rrq_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           opcode,
  input  logic [3:0]           thread_id,
  output logic                 item_valid,
  input  logic                 item_ready,
  output rrq_pkg::item_t       item
);

  localparam int PTR_W = $clog2(rrq_pkg::FIFO_DEPTH);
  localparam int OCC_W = $clog2(rrq_pkg::FIFO_DEPTH + 1);

  rrq_pkg::item_t   slots [rrq_pkg::FIFO_DEPTH];
  rrq_pkg::item_t   decoded;
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [OCC_W-1:0] occ;
  logic             push;
  logic             pop;

  // Decode the opcode; the reserved code becomes a no-op
  always_comb begin
    case (opcode)
      rrq_pkg::OP_ADMIT:  decoded.op = rrq_pkg::OP_ADMIT;
      rrq_pkg::OP_REMOVE: decoded.op = rrq_pkg::OP_REMOVE;
      rrq_pkg::OP_POP:    decoded.op = rrq_pkg::OP_POP;
      default:            decoded.op = rrq_pkg::OP_NOP;
    endcase
    decoded.id    = thread_id[rrq_pkg::ID_W-1:0];
    decoded.id_ok = (32'(thread_id) < 32'(rrq_pkg::MAX_THREADS));
  end

  assign in_ready   = (occ != OCC_W'(rrq_pkg::FIFO_DEPTH));
  assign item_valid = (occ != '0);
  assign item       = slots[rd_ptr];
  assign push       = in_valid && in_ready;
  assign pop        = item_valid && item_ready;

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= decoded;
    end
  end

  // Queue pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      occ    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        occ <= occ + OCC_W'(1);
      end else if (pop && !push) begin
        occ <= occ - OCC_W'(1);
      end
    end
  end

endmodule

// File: rtl/core/rrq_back.sv
// Back end: executes admit, remove and pop on the linked list and forms results.
module rrq_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  rrq_pkg::item_t       item,
  output logic                 res_valid,
  input  logic                 res_ready,
  output rrq_pkg::res_t        res,
  output rrq_pkg::status_t     status
);

  localparam int IW = rrq_pkg::ID_W;
  localparam int CW = rrq_pkg::CNT_W;

  rrq_pkg::state_t                state;
  rrq_pkg::state_t                state_next;
  rrq_pkg::item_t                 cur;
  rrq_pkg::item_t                 cur_next;
  logic [rrq_pkg::MAX_THREADS-1:0] queued;
  logic [rrq_pkg::MAX_THREADS-1:0] queued_next;
  logic [IW-1:0]                  head;
  logic [IW-1:0]                  head_next;
  logic [IW-1:0]                  tail;
  logic [IW-1:0]                  tail_next;
  logic [CW-1:0]                  count;
  logic [CW-1:0]                  count_next;
  rrq_pkg::res_t                  res_next;
  rrq_pkg::item_t                 rd_item;

  // Link table ports
  logic          nx_we;
  logic [IW-1:0] nx_wa;
  logic [IW-1:0] nx_wd;
  logic [IW-1:0] nx_ra;
  logic [IW-1:0] nx_rd;
  logic          pv_we;
  logic [IW-1:0] pv_wa;
  logic [IW-1:0] pv_wd;
  logic [IW-1:0] pv_ra;
  logic [IW-1:0] pv_rd;

  logic          fire;
  logic          hit;
  logic          at_head;
  logic          at_tail;

  rrq_ram #(.WIDTH(IW), .DEPTH(rrq_pkg::MAX_THREADS)) u_next_tbl (
    .clk     (clk),
    .we      (nx_we),
    .wr_addr (nx_wa),
    .wr_data (nx_wd),
    .rd_addr (nx_ra),
    .rd_data (nx_rd)
  );

  rrq_ram #(.WIDTH(IW), .DEPTH(rrq_pkg::MAX_THREADS)) u_prev_tbl (
    .clk     (clk),
    .we      (pv_we),
    .wr_addr (pv_wa),
    .wr_data (pv_wd),
    .rd_addr (pv_ra),
    .rd_data (pv_rd)
  );

  assign item_ready = (state == rrq_pkg::ST_IDLE);
  assign fire       = (state == rrq_pkg::ST_EXEC) && (!res_valid || res_ready);
  assign status     = '{queued: queued, count: count};

  // Read addresses: from the incoming word in idle, held during execute
  assign rd_item = (state == rrq_pkg::ST_IDLE) ? item : cur;
  assign nx_ra   = (rd_item.op == rrq_pkg::OP_POP) ? head : rd_item.id;
  assign pv_ra   = rd_item.id;

  // Next state
  always_comb begin
    case (state)
      rrq_pkg::ST_IDLE: state_next = item_valid ? rrq_pkg::ST_EXEC : rrq_pkg::ST_IDLE;
      rrq_pkg::ST_EXEC: state_next = fire ? rrq_pkg::ST_IDLE : rrq_pkg::ST_EXEC;
      default:          state_next = rrq_pkg::ST_IDLE;
    endcase
  end

  // List update and result for the word in execute
  always_comb begin
    cur_next    = (item_valid && item_ready) ? item : cur;
    hit         = cur.id_ok && queued[cur.id];
    at_head     = (head == cur.id);
    at_tail     = (tail == cur.id);
    queued_next = queued;
    head_next   = head;
    tail_next   = tail;
    count_next  = count;
    nx_we       = 1'b0;
    nx_wa       = tail;
    nx_wd       = cur.id;
    pv_we       = 1'b0;
    pv_wa       = cur.id;
    pv_wd       = tail;
    res_next.err    = rrq_pkg::ERR_OK;
    res_next.popped = '0;
    case (cur.op)
      rrq_pkg::OP_ADMIT: begin
        if (!cur.id_ok || queued[cur.id]) begin
          res_next.err = rrq_pkg::ERR_DUP;
        end else begin
          // append behind the tail, or start a fresh list
          if (count != '0) begin
            nx_we = fire;
            pv_we = fire;
          end else begin
            head_next = cur.id;
          end
          tail_next           = cur.id;
          queued_next[cur.id] = 1'b1;
          count_next          = count + CW'(1);
        end
      end
      rrq_pkg::OP_REMOVE: begin
        if (!hit) begin
          res_next.err = rrq_pkg::ERR_ABSENT;
        end else begin
          // bridge the neighbors around the removed id
          if (at_head) begin
            head_next = nx_rd;
          end else begin
            nx_we = fire;
            nx_wa = pv_rd;
            nx_wd = nx_rd;
          end
          if (at_tail) begin
            tail_next = pv_rd;
          end else begin
            pv_we = fire;
            pv_wa = nx_rd;
            pv_wd = pv_rd;
          end
          queued_next[cur.id] = 1'b0;
          count_next          = count - CW'(1);
        end
      end
      rrq_pkg::OP_POP: begin
        if (count == '0) begin
          res_next.err = rrq_pkg::ERR_EMPTY;
        end else begin
          res_next.popped = head;
          if (count > CW'(1)) begin
            head_next = nx_rd;
          end
          queued_next[head] = 1'b0;
          count_next        = count - CW'(1);
        end
      end
      default: begin
      end
    endcase
    res_next.length = count_next;
    res_next.empty  = (count_next == '0);
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rrq_pkg::ST_IDLE;
      queued    <= '0;
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (fire) begin
        queued    <= queued_next;
        head      <= head_next;
        tail      <= tail_next;
        count     <= count_next;
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Held command and result word
  always_ff @(posedge clk) begin
    cur <= cur_next;
    if (fire) begin
      res <= res_next;
    end
  end

endmodule

// File: tb/round_robin_ready_queue_core_tb.sv
// Testbench for the round-robin ready queue: directed and random words against a predictor.
module round_robin_ready_queue_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RUN_WORDS    = 1100;
  localparam int DRAIN_CYCLES = 12;
  localparam int PRINT_LIMIT  = 40;

  // One planned command word; hold makes the sender wait until all results are in
  typedef struct {
    rrq_pkg::op_t             op;
    logic [rrq_pkg::ID_W-1:0] id;
    bit                       hold;
  } cmd_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = '0;   // [1:0] opcode, [5:2] thread_id, [7:6] zero
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;         // [3:0] popped_id, [4] queue_empty,
                                // [9:5] queue_length, [11:10] error_code, [15:12] zero

  round_robin_ready_queue_core DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Reset held from time zero, then released once
  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
  end

  // Predicted queue contents: links by id, membership, ends and count
  logic [rrq_pkg::ID_W-1:0]        succ_of [rrq_pkg::MAX_THREADS];
  logic [rrq_pkg::ID_W-1:0]        pred_of [rrq_pkg::MAX_THREADS];
  logic [rrq_pkg::MAX_THREADS-1:0] in_queue  = '0;
  logic [rrq_pkg::ID_W-1:0]        head_id   = '0;
  logic [rrq_pkg::ID_W-1:0]        tail_id   = '0;
  logic [rrq_pkg::CNT_W-1:0]       occupancy = '0;

  cmd_t          cmd_backlog[$];
  rrq_pkg::res_t predicted_status[$];

  // Stimulus planning shadow: queue order as the generator expects it
  logic [rrq_pkg::ID_W-1:0]        plan_order[$];
  logic [rrq_pkg::MAX_THREADS-1:0] plan_present = '0;
  int planned_active = 0;

  int fail_count   = 0;
  int results_seen = 0;
  int words_sent   = 0;
  int peak_length  = 0;
  int err_tally [4] = '{default: 0};

  // Apply one command to the predicted queue and return the status word it yields
  function automatic rrq_pkg::res_t run_queue_op(rrq_pkg::op_t op,
                                                 logic [rrq_pkg::ID_W-1:0] id);
    rrq_pkg::res_t r;
    logic [rrq_pkg::ID_W-1:0] pred, succ, top;
    r = '0;
    r.err = rrq_pkg::ERR_OK;
    case (op)
      rrq_pkg::OP_ADMIT: begin
        if (in_queue[id]) begin
          r.err = rrq_pkg::ERR_DUP;
        end else begin
          succ_of[id] = '0;
          pred_of[id] = '0;
          if (occupancy == 0) begin
            head_id = id;
          end else begin
            succ_of[tail_id] = id;
            pred_of[id] = tail_id;
          end
          tail_id = id;
          in_queue[id] = 1'b1;
          occupancy = occupancy + rrq_pkg::CNT_W'(1);
        end
      end
      rrq_pkg::OP_REMOVE: begin
        if (!in_queue[id]) begin
          r.err = rrq_pkg::ERR_ABSENT;
        end else begin
          pred = pred_of[id];
          succ = succ_of[id];
          // unlink from either end or from the middle
          if (head_id == id) head_id = succ;
          else succ_of[pred] = succ;
          if (tail_id == id) tail_id = pred;
          else pred_of[succ] = pred;
          succ_of[id] = '0;
          pred_of[id] = '0;
          in_queue[id] = 1'b0;
          occupancy = occupancy - rrq_pkg::CNT_W'(1);
        end
      end
      rrq_pkg::OP_POP: begin
        if (occupancy == 0) begin
          r.err = rrq_pkg::ERR_EMPTY;
        end else begin
          top = head_id;
          r.popped = top;
          if (occupancy > 1) begin
            head_id = succ_of[top];
            pred_of[head_id] = '0;
          end
          succ_of[top] = '0;
          pred_of[top] = '0;
          in_queue[top] = 1'b0;
          occupancy = occupancy - rrq_pkg::CNT_W'(1);
        end
      end
      default: ;  // reserved opcode leaves the queue alone
    endcase
    r.empty  = (occupancy == 0);
    r.length = occupancy;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    if (fail_count < PRINT_LIMIT) $display("[%0t] ERROR: %s", $realtime, msg);
    fail_count++;
  endtask

  // Compare one received word with the oldest prediction
  task automatic check_result(rrq_pkg::res_t got);
    rrq_pkg::res_t want;
    results_seen++;
    if (predicted_status.size() == 0) begin
      report_mismatch($sformatf("result %0d arrived with no command outstanding",
                                results_seen));
      return;
    end
    want = predicted_status.pop_front();
    if (got.popped !== want.popped)
      report_mismatch($sformatf("result %0d popped_id: expected %0d, got %0d",
                                results_seen, want.popped, got.popped));
    if (got.empty !== want.empty)
      report_mismatch($sformatf("result %0d queue_empty: expected %0d, got %0d",
                                results_seen, want.empty, got.empty));
    if (got.length !== want.length)
      report_mismatch($sformatf("result %0d queue_length: expected %0d, got %0d",
                                results_seen, want.length, got.length));
    if (got.err !== want.err)
      report_mismatch($sformatf("result %0d error_code: expected %0d, got %0d",
                                results_seen, want.err, got.err));
    err_tally[int'(want.err)]++;
    if (int'(want.length) > peak_length) peak_length = int'(want.length);
  endtask

  // Sender: bursts of random length separated by random gaps
  int gap_left   = 0;
  int burst_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
    end else begin
      if (s_tvalid && s_tready) begin
        predicted_status.push_back(run_queue_op(rrq_pkg::op_t'(s_tdata[1:0]),
                                                s_tdata[5:2]));
        words_sent++;
      end
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (cmd_backlog.size() == 0 ||
                     (cmd_backlog[0].hold && predicted_status.size() != 0)) begin
          s_tvalid <= 1'b0;
        end else begin
          s_tvalid <= 1'b1;
          s_tdata  <= {2'b00, cmd_backlog[0].id, cmd_backlog[0].op};
          void'(cmd_backlog.pop_front());
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  // Receiver: ready follows a rotating mask, redrawn at random whenever mask_age wraps
  logic [7:0] ready_mask = 8'hff;
  int mask_age = 0;
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) check_result(rrq_pkg::res_t'(m_tdata[11:0]));
      if (mask_age == 63) begin
        mask_age = 0;
        case ($urandom_range(0, 3))
          0: ready_mask = 8'hff;
          1: ready_mask = 8'h01;
          default: ready_mask = 8'($urandom) | 8'h01;
        endcase
      end else begin
        mask_age++;
      end
      ready_mask = {ready_mask[0], ready_mask[7:1]};
      m_tready <= ready_mask[0];
    end
  end

  // Queue a command word and track the order the generator expects
  task automatic plan_cmd(rrq_pkg::op_t op, int id, bit hold = 1'b0);
    cmd_t c;
    c.op   = op;
    c.id   = id[rrq_pkg::ID_W-1:0];
    c.hold = hold;
    cmd_backlog.push_back(c);
    if (op != rrq_pkg::OP_NOP) planned_active++;
    case (op)
      rrq_pkg::OP_ADMIT: begin
        if (!plan_present[c.id]) begin
          plan_present[c.id] = 1'b1;
          plan_order.push_back(c.id);
        end
      end
      rrq_pkg::OP_REMOVE: begin
        if (plan_present[c.id]) begin
          plan_present[c.id] = 1'b0;
          for (int i = 0; i < plan_order.size(); i++) begin
            if (plan_order[i] == c.id) begin
              plan_order.delete(i);
              break;
            end
          end
        end
      end
      rrq_pkg::OP_POP: begin
        if (plan_order.size() != 0) plan_present[plan_order.pop_front()] = 1'b0;
      end
      default: ;
    endcase
  endtask

  function automatic int free_id();
    int id;
    do id = $urandom_range(0, rrq_pkg::MAX_THREADS - 1);
    while (plan_present[id]);
    return id;
  endfunction

  // Admit absent ids in random order until all sixteen are queued
  task automatic plan_fill(bit hold);
    while (plan_order.size() < rrq_pkg::MAX_THREADS) begin
      plan_cmd(rrq_pkg::OP_ADMIT, free_id(), hold);
      hold = 1'b0;
    end
  endtask

  // Pop everything, then one pop too many
  task automatic plan_drain(bit hold);
    while (plan_order.size() != 0) begin
      plan_cmd(rrq_pkg::OP_POP, $urandom_range(0, rrq_pkg::MAX_THREADS - 1), hold);
      hold = 1'b0;
    end
    plan_cmd(rrq_pkg::OP_POP, $urandom_range(0, rrq_pkg::MAX_THREADS - 1));
  endtask

  // Stimulus, end of run and verdict
  initial begin
    int picked;
    int base;
    int total_words;
    bit hold;

    // directed: errors on an empty queue, reserved opcode, extreme ids
    plan_cmd(rrq_pkg::OP_POP, 0);
    plan_cmd(rrq_pkg::OP_REMOVE, 15);
    plan_cmd(rrq_pkg::OP_NOP, 5);
    plan_cmd(rrq_pkg::OP_ADMIT, 0);
    plan_cmd(rrq_pkg::OP_ADMIT, 15);
    plan_cmd(rrq_pkg::OP_ADMIT, 7);
    plan_cmd(rrq_pkg::OP_ADMIT, 3);
    plan_cmd(rrq_pkg::OP_ADMIT, 15);    // duplicate
    plan_cmd(rrq_pkg::OP_REMOVE, 0);    // at head
    plan_cmd(rrq_pkg::OP_REMOVE, 3);    // at tail
    plan_cmd(rrq_pkg::OP_ADMIT, 9);
    plan_cmd(rrq_pkg::OP_ADMIT, 3);
    plan_cmd(rrq_pkg::OP_REMOVE, 9);    // in the middle
    plan_cmd(rrq_pkg::OP_REMOVE, 9);    // already gone
    plan_cmd(rrq_pkg::OP_POP, 10);      // id is ignored on pop
    plan_cmd(rrq_pkg::OP_POP, 0);
    plan_cmd(rrq_pkg::OP_POP, 0);
    plan_cmd(rrq_pkg::OP_POP, 0);       // empty again
    plan_cmd(rrq_pkg::OP_ADMIT, 6);
    plan_cmd(rrq_pkg::OP_REMOVE, 6);    // sole entry, head and tail at once
    plan_cmd(rrq_pkg::OP_NOP, 15);

    // random: start from a full queue after the pipeline has emptied
    base = planned_active;
    plan_fill(1'b1);
    plan_cmd(rrq_pkg::OP_ADMIT, $urandom_range(0, rrq_pkg::MAX_THREADS - 1));
    while (planned_active < base + RUN_WORDS) begin
      hold   = ($urandom_range(0, 149) == 0);
      picked = $urandom_range(0, 99);
      if (picked < 2) begin
        plan_fill(hold);
      end else if (picked < 4) begin
        plan_drain(hold);
      end else if (picked < 48) begin
        plan_cmd(rrq_pkg::OP_ADMIT,
                 (plan_order.size() < rrq_pkg::MAX_THREADS && $urandom_range(0, 7) != 0) ?
                 free_id() : $urandom_range(0, rrq_pkg::MAX_THREADS - 1), hold);
      end else if (picked < 68) begin
        plan_cmd(rrq_pkg::OP_REMOVE,
                 (plan_order.size() != 0 && $urandom_range(0, 4) != 0) ?
                 int'(plan_order[$urandom_range(0, plan_order.size() - 1)]) :
                 $urandom_range(0, rrq_pkg::MAX_THREADS - 1), hold);
      end else if (picked < 96) begin
        plan_cmd(rrq_pkg::OP_POP, $urandom_range(0, rrq_pkg::MAX_THREADS - 1), hold);
      end else begin
        plan_cmd(rrq_pkg::OP_NOP, $urandom_range(0, rrq_pkg::MAX_THREADS - 1), hold);
      end
    end
    total_words = cmd_backlog.size();

    // wait for every word to go in and every result to come out
    while (words_sent != total_words) @(posedge clk);
    while (predicted_status.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d command words and %0d results: %0d ok, %0d duplicate admits,",
             words_sent, results_seen, err_tally[rrq_pkg::ERR_OK],
             err_tally[rrq_pkg::ERR_DUP]);
    $display("%0d removes of absent ids, %0d pops of an empty queue; peak length %0d of %0d.",
             err_tally[rrq_pkg::ERR_ABSENT], err_tally[rrq_pkg::ERR_EMPTY], peak_length,
             rrq_pkg::MAX_THREADS);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("Timeout: %0d words sent, %0d results received", words_sent, results_seen);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
